[src/run_pair_bitmap_decoder_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the run-pair bitmap decoder
// Clocked checks on clk, switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef RUN_PAIR_BITMAP_DECODER_ASSERT_SVH
`define RUN_PAIR_BITMAP_DECODER_ASSERT_SVH

// same-cycle implication
`define RPBD_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// consequence in the cycle after the trigger
`define RPBD_CHECK_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

[src/rpbd_pkg.sv]
// ----------------------------------------------------------------------------
// rpbd_pkg
// Shared constants, codes and controller/datapath link types.
// ----------------------------------------------------------------------------
package rpbd_pkg;

  localparam int OUTPUT_LANES = 8;
  localparam int NUM_LANES    = 8;
  localparam int MAX_RESULTS  = 64;
  localparam int MAX_PIX      = MAX_RESULTS * OUTPUT_LANES;

  localparam int POS_W  = 10;
  localparam int PEND_W = 10;
  localparam int REM_W  = 32;

  localparam logic [PEND_W-1:0] MAX_PIX_P = PEND_W'(MAX_PIX);
  localparam logic [PEND_W-1:0] LANES_P   = PEND_W'(OUTPUT_LANES);
  localparam logic [3:0]        LANES_C   = 4'(OUTPUT_LANES);

  localparam logic [7:0] MAGIC [4] = '{8'h50, 8'h49, 8'h43, 8'h54};

  localparam logic [POS_W-1:0] POS_MAGIC_END = POS_W'(4);
  localparam logic [POS_W-1:0] POS_CODED     = POS_W'(4);
  localparam logic [POS_W-1:0] POS_DEPTH     = POS_W'(5);
  localparam logic [POS_W-1:0] POS_WIDTH_LO  = POS_W'(6);
  localparam logic [POS_W-1:0] POS_WIDTH_HI  = POS_W'(7);
  localparam logic [POS_W-1:0] POS_HEIGHT_LO = POS_W'(8);
  localparam logic [POS_W-1:0] POS_HEIGHT_HI = POS_W'(9);

  localparam int PAL_START = 14;
  localparam logic [POS_W-1:0] POS_PAL_ENTER      = POS_W'(PAL_START - 1);
  localparam logic [POS_W-1:0] POS_PAL_LAST_SMALL = POS_W'(PAL_START - 1 + 3 * 16);
  localparam logic [POS_W-1:0] POS_PAL_LAST_LARGE = POS_W'(PAL_START - 1 + 3 * 256);

  localparam logic [3:0] DEPTH_1 = 4'd1;
  localparam logic [3:0] DEPTH_2 = 4'd2;
  localparam logic [3:0] DEPTH_4 = 4'd4;
  localparam logic [3:0] DEPTH_8 = 4'd8;

  localparam logic [7:0] CODED_ON  = 8'd1;
  localparam logic [7:0] ERR_MAGIC = 8'd0;
  localparam logic [7:0] ERR_DEPTH = 8'd1;
  localparam logic [3:0] HDR_COUNT = 4'd6;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PALETTE = 2'd1,
    KIND_PIXELS  = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_HEADER  = 3'd1,
    OP_PALETTE = 3'd2,
    OP_DATA    = 3'd3,
    OP_GROUP   = 3'd4
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic hdr_err;
    logic hdr_to_pal;
    logic pal_last;
    logic rem_zero;
    logic data_more;
    logic data_end;
    logic grp_last;
    logic run_end;
  } sts_t;

endpackage

[src/rpbd_in_if.sv]
// ----------------------------------------------------------------------------
// rpbd_in_if
// Byte channel: one file byte per word, with a start-of-file mark.
// ----------------------------------------------------------------------------
interface rpbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

[src/rpbd_out_if.sv]
// ----------------------------------------------------------------------------
// rpbd_out_if
// Result channel: kind, eight lanes, lane count and end-of-image mark.
// ----------------------------------------------------------------------------
interface rpbd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] lane_0;
  logic [7:0] lane_1;
  logic [7:0] lane_2;
  logic [7:0] lane_3;
  logic [7:0] lane_4;
  logic [7:0] lane_5;
  logic [7:0] lane_6;
  logic [7:0] lane_7;
  logic [3:0] valid_count;
  logic       image_end;

  modport source (output valid, output kind, output lane_0, output lane_1, output lane_2,
                  output lane_3, output lane_4, output lane_5, output lane_6,
                  output lane_7, output valid_count, output image_end, input ready);
  modport sink (input valid, input kind, input lane_0, input lane_1, input lane_2,
                input lane_3, input lane_4, input lane_5, input lane_6,
                input lane_7, input valid_count, input image_end, output ready);
endinterface

[src/rpbd_ctrl.sv]
// ----------------------------------------------------------------------------
// rpbd_ctrl
// Decode phase sequencer: header, palette, pixel data, run emission, done.
// ----------------------------------------------------------------------------
`include "run_pair_bitmap_decoder_assert.svh"

module rpbd_ctrl import rpbd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic file_start,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_HEADER  = 5'b00001,
    ST_PALETTE = 5'b00010,
    ST_DATA    = 5'b00100,
    ST_RUN     = 5'b01000,
    ST_DONE    = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // no new word while a long run is still being split into groups
  assign in_ready = (state != ST_RUN) && sts.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.op = OP_NONE;
    if (accept) begin
      if (file_start) begin
        cmd.op = OP_HEADER;
      end else begin
        unique case (state)
          ST_HEADER:  cmd.op = OP_HEADER;
          ST_PALETTE: cmd.op = OP_PALETTE;
          ST_DATA:    cmd.op = OP_DATA;
          default:    cmd.op = OP_NONE;
        endcase
      end
    end else if ((state == ST_RUN) && sts.out_free) begin
      cmd.op = OP_GROUP;
    end
  end

  always_comb begin
    state_next = state;
    unique case (cmd.op)
      OP_HEADER: begin
        if (sts.hdr_err) begin
          state_next = ST_DONE;
        end else if (sts.hdr_to_pal) begin
          state_next = ST_PALETTE;
        end else begin
          state_next = ST_HEADER;
        end
      end
      OP_PALETTE: begin
        if (sts.pal_last) begin
          state_next = sts.rem_zero ? ST_DONE : ST_DATA;
        end
      end
      OP_DATA: begin
        if (sts.data_more) begin
          state_next = ST_RUN;
        end else if (sts.data_end) begin
          state_next = ST_DONE;
        end
      end
      OP_GROUP: begin
        if (sts.grp_last) begin
          state_next = sts.run_end ? ST_DONE : ST_DATA;
        end
      end
      default: state_next = state;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HEADER;
    end else begin
      state <= state_next;
    end
  end

  `RPBD_CHECK_NEXT(a_err_stops, (cmd.op == OP_HEADER) && sts.hdr_err, state == ST_DONE, "header error did not stop decoding")
  `RPBD_CHECK_NEXT(a_long_run, (cmd.op == OP_DATA) && sts.data_more, state == ST_RUN, "long run not split into groups")
  `RPBD_CHECK_NEXT(a_run_final, (cmd.op == OP_GROUP) && sts.grp_last && sts.run_end, state == ST_DONE, "image end missed after last run")

endmodule

[src/rpbd_datapath.sv]
// ----------------------------------------------------------------------------
// rpbd_datapath
// Header fields, byte counters, run expansion and the result register.
// ----------------------------------------------------------------------------
`include "run_pair_bitmap_decoder_assert.svh"

module rpbd_datapath import rpbd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        data_byte,
  input  logic              file_start,
  input  cmd_t              cmd,
  output sts_t              sts,
  rpbd_out_if.source        results
);

  logic [POS_W-1:0]  pos;
  logic              coded;
  logic [3:0]        depth;
  logic [15:0]       width;
  logic [7:0]        height_lo;
  logic [15:0]       row;
  logic [REM_W-1:0]  remaining;
  logic [7:0]        run_len;
  logic              awaiting;
  logic [PEND_W-1:0] pend;
  logic [7:0]        run_byte;
  logic              odd;
  logic              run_end;

  logic              out_valid;
  kind_t             kind_q;
  logic [7:0]        lane_q [NUM_LANES];
  logic [3:0]        vc_q;
  logic              end_q;

  logic [POS_W-1:0]  pos_eff;
  logic              magic_bad;
  logic              depth_ok;
  logic              depth_bad;
  logic [16:0]       row_sum;
  logic [15:0]       row_calc;
  logic              value_step;
  logic [7:0]        count;
  logic [7:0]        clip;
  logic              rem_zero_after;
  logic [8:0]        np;
  logic [PEND_W-1:0] cap;
  logic [3:0]        first_valid;
  logic [3:0]        pend_valid;
  logic [7:0]        grp_byte;
  logic              grp_odd;
  logic [3:0]        grp_vc;

  logic              emit;
  kind_t             kind_n;
  logic [7:0]        lane_n [NUM_LANES];
  logic [3:0]        vc_n;
  logic              end_n;

  // restart puts this byte at file position zero
  assign pos_eff   = file_start ? '0 : pos;
  assign magic_bad = (pos_eff < POS_MAGIC_END) && (data_byte != MAGIC[pos_eff[1:0]]);
  assign depth_ok  = (data_byte == {4'h0, DEPTH_1}) || (data_byte == {4'h0, DEPTH_2}) ||
                     (data_byte == {4'h0, DEPTH_4}) || (data_byte == {4'h0, DEPTH_8});
  assign depth_bad = (pos_eff == POS_DEPTH) && !depth_ok;

  // bytes per row: width rounded up to whole bytes
  always_comb begin
    unique case (depth)
      DEPTH_1: row_sum = (17'(width) + 17'd7) >> 3;
      DEPTH_2: row_sum = (17'(width) + 17'd3) >> 2;
      DEPTH_4: row_sum = (17'(width) + 17'd1) >> 1;
      default: row_sum = 17'(width);
    endcase
  end
  assign row_calc = row_sum[15:0];

  // pair decode: a count word is only stored
  assign value_step     = !coded || awaiting;
  assign count          = coded ? run_len : 8'd1;
  assign clip           = (remaining < REM_W'(count)) ? remaining[7:0] : count;
  assign rem_zero_after = (remaining == REM_W'(clip));
  assign np             = (depth == DEPTH_4) ? {clip, 1'b0} : {1'b0, clip};
  assign cap            = (PEND_W'(np) > MAX_PIX_P) ? MAX_PIX_P : PEND_W'(np);
  assign first_valid    = (cap > LANES_P) ? LANES_C : cap[3:0];
  assign pend_valid     = (pend > LANES_P) ? LANES_C : pend[3:0];

  assign grp_byte = (cmd.op == OP_GROUP) ? run_byte : data_byte;
  assign grp_odd  = (cmd.op == OP_GROUP) ? odd : 1'b0;
  assign grp_vc   = (cmd.op == OP_GROUP) ? pend_valid : first_valid;

  always_comb begin
    sts.out_free   = !out_valid || results.ready;
    sts.hdr_err    = magic_bad || depth_bad;
    sts.hdr_to_pal = (pos_eff >= POS_PAL_ENTER);
    sts.pal_last   = (pos >= ((depth == DEPTH_8) ? POS_PAL_LAST_LARGE : POS_PAL_LAST_SMALL));
    sts.rem_zero   = (remaining == '0);
    sts.data_more  = value_step && (cap > LANES_P);
    sts.data_end   = value_step && rem_zero_after;
    sts.grp_last   = (pend <= LANES_P);
    sts.run_end    = run_end;
  end

  always_comb begin
    emit   = 1'b0;
    kind_n = KIND_PIXELS;
    vc_n   = '0;
    end_n  = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_n[i] = '0;
    end
    unique case (cmd.op)
      OP_HEADER: begin
        if (sts.hdr_err) begin
          emit      = 1'b1;
          kind_n    = KIND_ERROR;
          lane_n[0] = magic_bad ? ERR_MAGIC : ERR_DEPTH;
          vc_n      = 4'd1;
          end_n     = 1'b1;
        end else if (pos_eff == POS_HEIGHT_HI) begin
          emit      = 1'b1;
          kind_n    = KIND_HEADER;
          lane_n[0] = {4'h0, depth};
          lane_n[1] = width[7:0];
          lane_n[2] = width[15:8];
          lane_n[3] = height_lo;
          lane_n[4] = data_byte;
          lane_n[5] = {7'd0, coded};
          vc_n      = HDR_COUNT;
        end
      end
      OP_PALETTE: begin
        emit      = 1'b1;
        kind_n    = KIND_PALETTE;
        lane_n[0] = {data_byte[5:0], 2'b00};
        vc_n      = 4'd1;
        end_n     = sts.pal_last && sts.rem_zero;
      end
      OP_DATA, OP_GROUP: begin
        if ((cmd.op == OP_GROUP) || (value_step && (cap != '0))) begin
          emit   = 1'b1;
          vc_n   = grp_vc;
          end_n  = (cmd.op == OP_GROUP) ? (run_end && sts.grp_last)
                                        : (rem_zero_after && (cap <= LANES_P));
          for (int i = 0; i < NUM_LANES; i++) begin
            if (4'(i) < grp_vc) begin
              if (depth == DEPTH_4) begin
                // high nibble on even pixel index
                lane_n[i] = (grp_odd ^ 1'(i)) ? {4'h0, grp_byte[3:0]}
                                              : {4'h0, grp_byte[7:4]};
              end else begin
                lane_n[i] = grp_byte;
              end
            end
          end
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      awaiting  <= 1'b0;
      remaining <= '0;
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_HEADER: begin
          pos      <= pos_eff + POS_W'(1);
          awaiting <= 1'b0;
          if (pos_eff == POS_HEIGHT_HI) begin
            remaining <= REM_W'(row) * REM_W'({data_byte, height_lo});
          end
        end
        OP_PALETTE: pos <= pos + POS_W'(1);
        OP_DATA: begin
          if (!value_step) begin
            awaiting <= 1'b1;
          end else begin
            awaiting  <= 1'b0;
            remaining <= remaining - REM_W'(clip);
            pend      <= cap - PEND_W'(first_valid);
          end
        end
        OP_GROUP: pend <= pend - PEND_W'(pend_valid);
        default: pend <= pend;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_HEADER) begin
      unique case (pos_eff)
        POS_CODED:     coded       <= (data_byte == CODED_ON);
        POS_DEPTH:     depth       <= data_byte[3:0];
        POS_WIDTH_LO:  width[7:0]  <= data_byte;
        POS_WIDTH_HI:  width[15:8] <= data_byte;
        POS_HEIGHT_LO: begin
          height_lo <= data_byte;
          row       <= row_calc;
        end
        default: row <= row;
      endcase
    end
    if ((cmd.op == OP_DATA) && !value_step) begin
      run_len <= data_byte;
    end
    if ((cmd.op == OP_DATA) && value_step) begin
      run_byte <= data_byte;
      odd      <= first_valid[0];
      run_end  <= rem_zero_after;
    end else if (cmd.op == OP_GROUP) begin
      odd <= odd ^ pend_valid[0];
    end
    if (emit) begin
      kind_q <= kind_n;
      vc_q   <= vc_n;
      end_q  <= end_n;
      for (int i = 0; i < NUM_LANES; i++) begin
        lane_q[i] <= lane_n[i];
      end
    end
  end

  assign results.valid       = out_valid;
  assign results.kind        = kind_q;
  assign results.lane_0      = lane_q[0];
  assign results.lane_1      = lane_q[1];
  assign results.lane_2      = lane_q[2];
  assign results.lane_3      = lane_q[3];
  assign results.lane_4      = lane_q[4];
  assign results.lane_5      = lane_q[5];
  assign results.lane_6      = lane_q[6];
  assign results.lane_7      = lane_q[7];
  assign results.valid_count = vc_q;
  assign results.image_end   = end_q;

  `RPBD_CHECK(a_out_count, results.valid |-> (results.valid_count != 4'd0) && (results.valid_count <= LANES_C), "result word with bad lane count")
  `RPBD_CHECK(a_group_pixels, (cmd.op == OP_GROUP) |-> (pend != '0), "group issued with no pixels left")
  `RPBD_CHECK_NEXT(a_rem_down, cmd.op != OP_HEADER, remaining <= $past(remaining), "byte count grew outside the header")

endmodule

[src/run_pair_bitmap_decoder.sv]
// ----------------------------------------------------------------------------
// run_pair_bitmap_decoder
// Bitmap file decoder: header check, palette, run-pair pixel expansion.
// ----------------------------------------------------------------------------
// Usage:
//   bytes   : one file byte per word; file_start marks byte 0 of a new file
//             and restarts decoding at any point.
//   results : header word, one word per palette component (shifted left by
//             two), then pixel words of up to eight lanes; an error word on a
//             bad magic or depth. image_end marks the last word of an image.
// Registering: a result word shows in the cycle after the byte that causes it.
// Throughput: one byte per cycle while each byte gives at most one word.
//   A coded pair whose run needs more than one word holds the byte channel
//   until its last group of up to eight lanes is out, one group per cycle.
// Stall: results sit in an output register; while it is full and not taken,
//   bytes and group emission both wait. Nothing is dropped.
// Reset: rst (synchronous) returns to the header phase at file byte 0 and
//   empties the output register; no clearing pass.
// ----------------------------------------------------------------------------
module run_pair_bitmap_decoder import rpbd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rpbd_in_if.sink    bytes,
  rpbd_out_if.source results
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign bytes.ready = in_ready;

  rpbd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (bytes.valid),
    .file_start (bytes.file_start),
    .in_ready   (in_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rpbd_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (bytes.data_byte),
    .file_start (bytes.file_start),
    .cmd        (cmd),
    .sts        (sts),
    .results    (results)
  );

endmodule

[tb/tb_run_pair_bitmap_decoder.sv]
// ----------------------------------------------------------------------------
// tb_run_pair_bitmap_decoder
// Feeds bitmap files byte by byte: a short table of header and error cases,
// then random files (coded and plain, depths 1, 2 and 4, empty images, clipped
// and empty runs, cut-short files, bad magic and depth). Every result word is
// compared field by field with a local decoder model or a typed table word,
// under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_run_pair_bitmap_decoder;
  import rpbd_pkg::*;

  typedef struct packed {
    kind_t                     kind;
    logic [NUM_LANES-1:0][7:0] lane;
    logic [3:0]                count;
    logic                      ends_image;
  } word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       typed;
    word_t      want;
  } stim_word_t;

  typedef enum logic [1:0] {DEC_HEADER, DEC_PALETTE, DEC_PIXELS, DEC_IDLE} dec_phase_t;

  localparam word_t NO_WORD = '0;
  localparam int    N_ROWS  = 24;
  localparam int    N_BYTES = 350;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rpbd_in_if  byte_ch ();
  rpbd_out_if word_ch ();

  run_pair_bitmap_decoder u_top (
    .clk     (clk),
    .rst     (rst),
    .bytes   (byte_ch),
    .results (word_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder model state
  dec_phase_t       dec_phase;
  logic [POS_W-1:0] dec_pos;
  logic             dec_coded;
  logic [3:0]       dec_depth;
  logic [15:0]      img_w;
  logic [15:0]      img_h;
  logic [31:0]      bytes_left;
  logic [7:0]       run_count;
  logic             want_value;

  word_t      fresh_q [$];
  word_t      expected_q [$];
  stim_word_t stim_q [$];
  stim_word_t on_wire;
  stim_word_t dir_rows [N_ROWS];

  int fails = 0;
  int n_queued = 0;
  int n_bytes = 0;
  int n_files = 0;
  int n_words = 0;
  int n_pix_words = 0;
  int n_err_words = 0;
  int in_gap = 0;
  int in_burst = 0;
  int out_hold = 0;
  int out_burst = 0;

  function automatic word_t err_word(input logic [7:0] code);
    word_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.lane[0] = code;
    r.count = 4'd1;
    r.ends_image = 1'b1;
    return r;
  endfunction

  function automatic word_t hdr_word(input logic [3:0] dep, input logic [15:0] w,
                                     input logic [15:0] h, input logic c);
    word_t r;
    r = '0;
    r.kind = KIND_HEADER;
    r.lane[0] = {4'd0, dep};
    r.lane[1] = w[7:0];
    r.lane[2] = w[15:8];
    r.lane[3] = h[7:0];
    r.lane[4] = h[15:8];
    r.lane[5] = {7'd0, c};
    r.count = HDR_COUNT;
    return r;
  endfunction

  function automatic void restart_decode();
    dec_phase = DEC_HEADER;
    dec_pos = '0;
    dec_coded = 1'b0;
    dec_depth = '0;
    img_w = '0;
    img_h = '0;
    bytes_left = '0;
    run_count = '0;
    want_value = 1'b0;
  endfunction

  // Work out the words one byte gives, into fresh_q.
  function automatic void decode_byte(input logic [7:0] b, input logic start);
    logic [POS_W-1:0] p;
    logic             last;
    longint unsigned  per_px, row;
    int               count, np, nres, nv, i, k;
    logic [7:0]       pix [$];
    word_t            w;
    if (start) restart_decode();
    case (dec_phase)
      DEC_HEADER: begin
        p = dec_pos;
        dec_pos = dec_pos + 1'b1;
        if (p < POS_MAGIC_END) begin
          if (b != MAGIC[p[1:0]]) begin
            fresh_q.push_back(err_word(ERR_MAGIC));
            dec_phase = DEC_IDLE;
          end
        end else if (p == POS_CODED) begin
          dec_coded = (b == CODED_ON);
        end else if (p == POS_DEPTH) begin
          if (b != 8'(DEPTH_1) && b != 8'(DEPTH_2) && b != 8'(DEPTH_4) &&
              b != 8'(DEPTH_8)) begin
            fresh_q.push_back(err_word(ERR_DEPTH));
            dec_phase = DEC_IDLE;
          end else begin
            dec_depth = b[3:0];
          end
        end else if (p == POS_WIDTH_LO) begin
          img_w[7:0] = b;
        end else if (p == POS_WIDTH_HI) begin
          img_w[15:8] = b;
        end else if (p == POS_HEIGHT_LO) begin
          img_h[7:0] = b;
        end else if (p == POS_HEIGHT_HI) begin
          img_h[15:8] = b;
          per_px = 8 / dec_depth;
          row = (longint'(img_w) + per_px - 1) / per_px;
          bytes_left = 32'(row * longint'(img_h));
          fresh_q.push_back(hdr_word(dec_depth, img_w, img_h, dec_coded));
        end else if (p >= POS_PAL_ENTER) begin
          dec_phase = DEC_PALETTE;
        end
      end
      DEC_PALETTE: begin
        p = dec_pos;
        dec_pos = dec_pos + 1'b1;
        last = (dec_depth == DEPTH_8) ? (p >= POS_PAL_LAST_LARGE) : (p >= POS_PAL_LAST_SMALL);
        w = '0;
        w.kind = KIND_PALETTE;
        w.lane[0] = {b[5:0], 2'b00};
        w.count = 4'd1;
        if (last) begin
          if (bytes_left == 0) begin
            dec_phase = DEC_IDLE;
            w.ends_image = 1'b1;
          end else begin
            dec_phase = DEC_PIXELS;
          end
        end
        fresh_q.push_back(w);
      end
      DEC_PIXELS: begin
        if (dec_coded && !want_value) begin
          // first byte of a pair: hold the count
          run_count = b;
          want_value = 1'b1;
          return;
        end
        count = dec_coded ? int'(run_count) : 1;
        want_value = 1'b0;
        if (count > bytes_left) count = bytes_left;
        for (i = 0; i < count; i++) begin
          if (dec_depth == DEPTH_4) begin
            pix.push_back({4'd0, b[7:4]});
            pix.push_back({4'd0, b[3:0]});
          end else begin
            pix.push_back(b);
          end
        end
        bytes_left = bytes_left - 32'(count);
        if (bytes_left == 0) dec_phase = DEC_IDLE;
        np = pix.size();
        nres = (np + OUTPUT_LANES - 1) / OUTPUT_LANES;
        if (nres > MAX_RESULTS) nres = MAX_RESULTS;
        for (k = 0; k < nres; k++) begin
          w = '0;
          w.kind = KIND_PIXELS;
          nv = np - k * OUTPUT_LANES;
          if (nv > OUTPUT_LANES) nv = OUTPUT_LANES;
          for (i = 0; i < nv; i++) w.lane[i] = pix[k * OUTPUT_LANES + i];
          w.count = 4'(nv);
          w.ends_image = (bytes_left == 0) && (k == nres - 1);
          fresh_q.push_back(w);
        end
      end
      default: ;
    endcase
  endfunction

  // Mostly no pause, some short ones, a few long, and bursts with none at all.
  function automatic int pick_pause(ref int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Queue one random file.
  function automatic void add_file();
    logic [7:0] f [$];
    logic [7:0] cb, v;
    logic [3:0] dep;
    logic [15:0] w, h;
    stim_word_t sw;
    int r, k, left, cnt, per_px, pal, i;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      // magic broken at a random position
      k = $urandom_range(0, 3);
      for (i = 0; i < k; i++) f.push_back(MAGIC[i]);
      f.push_back(MAGIC[k] ^ 8'($urandom_range(1, 255)));
      repeat ($urandom_range(0, 4)) f.push_back(8'($urandom));
    end else if (r < 24) begin
      for (i = 0; i < 4; i++) f.push_back(MAGIC[i]);
      f.push_back(8'($urandom));
      do
        v = $urandom_range(0, 1) ? 8'($urandom_range(0, 16)) : 8'($urandom);
      while (v == 8'(DEPTH_1) || v == 8'(DEPTH_2) || v == 8'(DEPTH_4) || v == 8'(DEPTH_8));
      f.push_back(v);
      repeat ($urandom_range(0, 4)) f.push_back(8'($urandom));
    end else begin
      k = $urandom_range(0, 9);
      cb = (k < 6) ? CODED_ON : (k < 9) ? 8'd0 : 8'($urandom_range(2, 255));
      case ($urandom_range(0, 2))
        0: dep = DEPTH_1;
        1: dep = DEPTH_2;
        default: dep = DEPTH_4;
      endcase
      k = $urandom_range(0, 9);
      if (k == 0) begin
        w = '0;
        h = 16'($urandom);
      end else if (k == 1) begin
        w = 16'($urandom);
        h = '0;
      end else if (cb == CODED_ON) begin
        w = 16'($urandom_range(1, 96));
        h = 16'($urandom_range(1, 8));
      end else begin
        w = 16'($urandom_range(1, 32));
        h = 16'($urandom_range(1, 4));
      end
      for (i = 0; i < 4; i++) f.push_back(MAGIC[i]);
      f.push_back(cb);
      f.push_back({4'd0, dep});
      f.push_back(w[7:0]);
      f.push_back(w[15:8]);
      f.push_back(h[7:0]);
      f.push_back(h[15:8]);
      repeat (4) f.push_back(8'($urandom));
      pal = (dep == DEPTH_8) ? 3 * 256 : 3 * 16;
      repeat (pal) f.push_back(8'($urandom));
      per_px = 8 / dep;
      left = ((int'(w) + per_px - 1) / per_px) * int'(h);
      if (cb == CODED_ON) begin
        while (left > 0) begin
          k = $urandom_range(0, 9);
          if (k == 0) cnt = 0;
          else if (k == 1) cnt = 255;
          else if (k == 2) cnt = (left > 255) ? 255 : left;
          else cnt = $urandom_range(1, 12);
          f.push_back(8'(cnt));
          f.push_back(8'($urandom));
          left -= (cnt > left) ? left : cnt;
        end
      end else begin
        repeat (left) f.push_back(8'($urandom));
      end
      // trailing bytes past the image end are dropped by the block
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) f.push_back(8'($urandom));
    end
    // cut the file short now and then; the next start restarts the decode
    if (f.size() > 1 && $urandom_range(0, 9) == 0)
      f = f[0:$urandom_range(0, f.size() - 2)];
    foreach (f[i]) begin
      sw = '0;
      sw.data = f[i];
      sw.start = (i == 0);
      stim_q.push_back(sw);
    end
    n_files++;
  endfunction

  // byte channel: drive, and model each accepted word
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
      restart_decode();
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        fresh_q.delete();
        decode_byte(on_wire.data, on_wire.start);
        if (on_wire.typed) expected_q.push_back(on_wire.want);
        else foreach (fresh_q[i]) expected_q.push_back(fresh_q[i]);
        n_bytes++;
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          byte_ch.valid <= 1'b0;
        end else if (stim_q.size() != 0) begin
          on_wire = stim_q.pop_front();
          byte_ch.valid <= 1'b1;
          byte_ch.data_byte <= on_wire.data;
          byte_ch.file_start <= on_wire.start;
          in_gap = pick_pause(in_burst);
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result channel: stall at random, compare each accepted word
  always @(posedge clk) begin
    word_t got, want;
    if (rst) begin
      word_ch.ready <= 1'b0;
    end else begin
      if (word_ch.valid && word_ch.ready) begin
        got.kind = kind_t'(word_ch.kind);
        got.lane[0] = word_ch.lane_0;
        got.lane[1] = word_ch.lane_1;
        got.lane[2] = word_ch.lane_2;
        got.lane[3] = word_ch.lane_3;
        got.lane[4] = word_ch.lane_4;
        got.lane[5] = word_ch.lane_5;
        got.lane[6] = word_ch.lane_6;
        got.lane[7] = word_ch.lane_7;
        got.count = word_ch.valid_count;
        got.ends_image = word_ch.image_end;
        n_words++;
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected: kind %0d lane_0 0x%02h",
                 got.kind, got.lane[0]);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (want.kind == KIND_PIXELS) n_pix_words++;
          if (want.kind == KIND_ERROR) n_err_words++;
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            fails++;
          end
          for (int i = 0; i < NUM_LANES; i++)
            if (got.lane[i] !== want.lane[i]) begin
              $error("lane_%0d: expected 0x%02h, got 0x%02h", i, want.lane[i], got.lane[i]);
              fails++;
            end
          if (got.count !== want.count) begin
            $error("valid_count: expected %0d, got %0d", want.count, got.count);
            fails++;
          end
          if (got.ends_image !== want.ends_image) begin
            $error("image_end: expected %0b, got %0b", want.ends_image, got.ends_image);
            fails++;
          end
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        word_ch.ready <= 1'b0;
      end else begin
        word_ch.ready <= 1'b1;
        out_hold = pick_pause(out_burst);
      end
    end
  end

  initial begin
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = 8'd0;
    byte_ch.file_start = 1'b0;
    word_ch.ready = 1'b0;

    // header and error cases; expected words typed in where they are obvious
    dir_rows = '{
      {8'h51,    1'b0, 1'b1, err_word(ERR_MAGIC)},  // no start after reset
      {MAGIC[0], 1'b0, 1'b0, NO_WORD},              // dropped until a start
      {MAGIC[0], 1'b1, 1'b0, NO_WORD},
      {MAGIC[1], 1'b0, 1'b0, NO_WORD},
      {MAGIC[2], 1'b0, 1'b0, NO_WORD},
      {8'h58,    1'b0, 1'b1, err_word(ERR_MAGIC)},  // last magic byte wrong
      {MAGIC[0], 1'b1, 1'b0, NO_WORD},
      {MAGIC[1], 1'b0, 1'b0, NO_WORD},
      {MAGIC[2], 1'b0, 1'b0, NO_WORD},
      {MAGIC[3], 1'b0, 1'b0, NO_WORD},
      {CODED_ON, 1'b0, 1'b0, NO_WORD},
      {8'h03,    1'b0, 1'b1, err_word(ERR_DEPTH)},
      {MAGIC[0], 1'b1, 1'b0, NO_WORD},
      {MAGIC[1], 1'b0, 1'b0, NO_WORD},
      {MAGIC[2], 1'b0, 1'b0, NO_WORD},
      {MAGIC[3], 1'b0, 1'b0, NO_WORD},
      {8'h00,    1'b0, 1'b0, NO_WORD},
      {4'd0, DEPTH_8, 1'b0, 1'b0, NO_WORD},
      {8'hff,    1'b0, 1'b0, NO_WORD},
      {8'hff,    1'b0, 1'b0, NO_WORD},
      {8'hff,    1'b0, 1'b0, NO_WORD},
      {8'hff,    1'b0, 1'b1, hdr_word(DEPTH_8, 16'hffff, 16'hffff, 1'b0)},
      {8'h00,    1'b1, 1'b1, err_word(ERR_MAGIC)},  // restart inside the header
      {8'hff,    1'b1, 1'b1, err_word(ERR_MAGIC)}
    };
    foreach (dir_rows[i]) stim_q.push_back(dir_rows[i]);

    // random files up to the byte budget; the last one may end early
    while (stim_q.size() < N_BYTES) add_file();
    if (stim_q.size() > N_BYTES) stim_q = stim_q[0:N_BYTES-1];
    n_queued = stim_q.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (n_bytes < n_queued) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Fed %0d bytes over %0d files (table plus random), %0d result words compared",
             n_bytes, n_files, n_words);
    $display("  of which %0d pixel words and %0d error words", n_pix_words, n_err_words);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hard stop, long past any correct run
  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/rpbd_pkg.sv
src/rpbd_in_if.sv
src/rpbd_out_if.sv
src/rpbd_ctrl.sv
src/rpbd_datapath.sv
src/run_pair_bitmap_decoder.sv
tb/tb_run_pair_bitmap_decoder.sv
